### rtl/core/assert_macros.svh
// Assertion macros shared by the core RTL.
// Define ASSERT_OFF to compile every assertion away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

### rtl/core/rpe_pkg.sv
`timescale 1ns / 1ps

package rpe_pkg;

    localparam int unsigned ROTARY_PAIRS  = 16;
    localparam int unsigned MAX_POSITIONS = 1024;
    localparam int unsigned TBL_DEPTH     = MAX_POSITIONS * ROTARY_PAIRS;
    localparam int unsigned TBL_AW        = $clog2(TBL_DEPTH);

    localparam int unsigned DATA_W     = 32;
    localparam int unsigned TRIG_W     = 18;
    localparam int unsigned POS_W      = 10;
    localparam int unsigned SLOT_W     = 4;
    localparam int unsigned SPLIT_W    = 11;
    localparam int unsigned PROD_SHIFT = 16;
    localparam int unsigned PROD_W     = DATA_W + TRIG_W - PROD_SHIFT;
    localparam int unsigned SUM_W      = PROD_W + 1;

    localparam logic [SPLIT_W-1:0] SPLIT_RESET = SPLIT_W'(800);

    typedef enum logic {
        OP_LOAD   = 1'b0,
        OP_ROTATE = 1'b1
    } t_op;

    typedef logic signed [DATA_W-1:0] t_data;
    typedef logic signed [TRIG_W-1:0] t_trig;
    typedef logic signed [PROD_W-1:0] t_prod;
    typedef logic signed [SUM_W-1:0]  t_sum;
    typedef logic [TBL_AW-1:0]        t_tbl_addr;

    typedef struct packed {
        t_trig cos_v;
        t_trig sin_v;
    } t_trig_pair;

    // Stage advance strobes shared by all lanes.
    typedef struct packed {
        logic adv_mul;
        logic adv_sum;
    } t_lane_ctrl;

endpackage

### rtl/core/rpe_ifs.sv
`timescale 1ns / 1ps

interface rpe_in_if import rpe_pkg::*; ();
    logic                valid;
    logic                ready;
    t_op                 operation;
    logic [POS_W-1:0]    position;
    logic [SLOT_W-1:0]   pair_slot;
    t_trig               trig_cos;
    t_trig               trig_sin;
    t_data               q_first;
    t_data               q_second;
    t_data               k_first;
    t_data               k_second;

    modport source (
        output valid, operation, position, pair_slot, trig_cos, trig_sin,
               q_first, q_second, k_first, k_second,
        input  ready
    );
    modport sink (
        input  valid, operation, position, pair_slot, trig_cos, trig_sin,
               q_first, q_second, k_first, k_second,
        output ready
    );
endinterface

interface rpe_out_if import rpe_pkg::*; ();
    logic                valid;
    logic                ready;
    t_data               q_first_out;
    t_data               q_second_out;
    t_data               k_first_out;
    t_data               k_second_out;
    logic                cache_select;
    logic [POS_W-1:0]    cache_row;

    modport source (
        output valid, q_first_out, q_second_out, k_first_out, k_second_out,
               cache_select, cache_row,
        input  ready
    );
    modport sink (
        input  valid, q_first_out, q_second_out, k_first_out, k_second_out,
               cache_select, cache_row,
        output ready
    );
endinterface

### rtl/core/rpe_trig_mem.sv
`timescale 1ns / 1ps

module rpe_trig_mem import rpe_pkg::*; (
    input  logic       i_clk,
    input  logic       i_we,
    input  t_tbl_addr  i_waddr,
    input  t_trig_pair i_wdata,
    input  logic       i_re,
    input  t_tbl_addr  i_raddr,
    output t_trig_pair o_rdata
);

    t_trig_pair r_mem [TBL_DEPTH];
    t_trig_pair r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Hold read data while the pipeline stalls.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/rpe_lane.sv
`timescale 1ns / 1ps

module rpe_lane import rpe_pkg::*; (
    input  logic       i_clk,
    input  t_lane_ctrl i_ctrl,
    input  logic       i_subtract,
    input  t_data      i_a,
    input  t_data      i_b,
    input  t_trig      i_cos,
    input  t_trig      i_sin,
    output t_data      o_result
);

    localparam t_data DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam t_data DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    logic signed [DATA_W+TRIG_W-1:0] n_prod_a;
    logic signed [DATA_W+TRIG_W-1:0] n_prod_b;
    t_prod r_prod_a;
    t_prod r_prod_b;
    logic  r_subtract;
    t_sum  n_sum;
    t_data n_result;
    t_data r_result;

    assign n_prod_a = i_a * i_cos;
    assign n_prod_b = i_b * i_sin;

    // Drop the low fraction bits: an arithmetic shift floors.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.adv_mul) begin
            r_prod_a   <= n_prod_a[DATA_W+TRIG_W-1:PROD_SHIFT];
            r_prod_b   <= n_prod_b[DATA_W+TRIG_W-1:PROD_SHIFT];
            r_subtract <= i_subtract;
        end
    end

    always_comb begin
        if (r_subtract) begin
            n_sum = SUM_W'(r_prod_a) - SUM_W'(r_prod_b);
        end else begin
            n_sum = SUM_W'(r_prod_a) + SUM_W'(r_prod_b);
        end
        if (n_sum > SUM_W'(DATA_MAX)) begin
            n_result = DATA_MAX;
        end else if (n_sum < SUM_W'(DATA_MIN)) begin
            n_result = DATA_MIN;
        end else begin
            n_result = n_sum[DATA_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.adv_sum) begin
            r_result <= n_result;
        end
    end

    assign o_result = r_result;

endmodule

### rtl/core/rotary_position_embedding_pair_core.sv
// A rotate transaction passes the registered stages S1, S2 and S3 to the output.
// Throughput: one transaction per cycle unless stalled; loads give no result.
// A stalled output holds its result while bubbles ahead still fill.
// Reset (i_rst_n low, synchronous) clears all stage valids, sets the split to 800.
// The trig table is not cleared; each entry is undefined until loaded.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rotary_position_embedding_pair_core import rpe_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    rpe_in_if.sink             i_in,
    rpe_out_if.source          o_out,
    input  logic               i_cfg_we,
    input  logic [SPLIT_W-1:0] i_cfg_wdata
);

    // Pipeline:
    //   S1: trig table read (registered) and input operands captured
    //   S2: eight truncated products, one pair per lane
    //   S3: saturated sum or difference, merged with the cache routing
    // Each stage advances when it is empty or the stage after it advances.

    logic               adv1;
    logic               adv2;
    logic               adv3;
    logic               accept;
    logic               accept_rotate;
    logic               accept_load;
    t_lane_ctrl         lane_ctrl;
    t_tbl_addr          tbl_addr;
    t_trig_pair         trig_write;
    t_trig_pair         trig_read;

    logic [SPLIT_W-1:0] r_split;
    logic               r_s1_valid;
    logic               r_s2_valid;
    logic               r_s3_valid;

    t_data              r_s1_q_first;
    t_data              r_s1_q_second;
    t_data              r_s1_k_first;
    t_data              r_s1_k_second;
    logic               r_s1_sel;
    logic [POS_W-1:0]   r_s1_row;
    logic               r_s2_sel;
    logic [POS_W-1:0]   r_s2_row;
    logic               r_s3_sel;
    logic [POS_W-1:0]   r_s3_row;

    logic               n_sel;
    logic [SPLIT_W-1:0] n_row_diff;
    logic [POS_W-1:0]   n_row;

    t_data              lane_q_first;
    t_data              lane_q_second;
    t_data              lane_k_first;
    t_data              lane_k_second;

    // Stall control: a bubble in any stage lets the input side keep moving.
    assign adv3 = !r_s3_valid || o_out.ready;
    assign adv2 = !r_s2_valid || adv3;
    assign adv1 = !r_s1_valid || adv2;

    // Hold the input off while reset is asserted so no transaction is dropped.
    assign i_in.ready    = adv1 && i_rst_n;
    assign accept        = i_in.valid && adv1 && i_rst_n;
    assign accept_rotate = accept && (i_in.operation == OP_ROTATE);
    assign accept_load   = accept && (i_in.operation == OP_LOAD);

    assign lane_ctrl.adv_mul = adv2;
    assign lane_ctrl.adv_sum = adv3;

    // Both table dimensions are powers of two: the entry index is the
    // concatenation of position and pair slot.
    assign tbl_addr          = TBL_AW'({i_in.position, i_in.pair_slot});
    assign trig_write.cos_v  = i_in.trig_cos;
    assign trig_write.sin_v  = i_in.trig_sin;

    rpe_trig_mem u_trig_mem (
        .i_clk   (i_clk),
        .i_we    (accept_load),
        .i_waddr (tbl_addr),
        .i_wdata (trig_write),
        .i_re    (adv1),
        .i_raddr (tbl_addr),
        .o_rdata (trig_read)
    );

    // Key cache routing: positions at or above the split go to the second cache.
    always_comb begin
        n_sel      = {1'b0, i_in.position} >= r_split;
        n_row_diff = {1'b0, i_in.position} - r_split;
        n_row      = n_sel ? n_row_diff[POS_W-1:0] : i_in.position;
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_split    <= SPLIT_RESET;
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_split <= i_cfg_wdata;
            end
            if (adv1) begin
                r_s1_valid <= accept_rotate;
            end
            if (adv2) begin
                r_s2_valid <= r_s1_valid;
            end
            if (adv3) begin
                r_s3_valid <= r_s2_valid;
            end
        end
    end

    // Payload: advance with the stage, hold otherwise.
    always_ff @(posedge i_clk) begin
        if (adv1) begin
            r_s1_q_first  <= i_in.q_first;
            r_s1_q_second <= i_in.q_second;
            r_s1_k_first  <= i_in.k_first;
            r_s1_k_second <= i_in.k_second;
            r_s1_sel      <= n_sel;
            r_s1_row      <= n_row;
        end
        if (adv2) begin
            r_s2_sel <= r_s1_sel;
            r_s2_row <= r_s1_row;
        end
        if (adv3) begin
            r_s3_sel <= r_s2_sel;
            r_s3_row <= r_s2_row;
        end
    end

    // Four lanes, one per rotated element; first elements subtract.
    rpe_lane u_lane_q_first (
        .i_clk      (i_clk),
        .i_ctrl     (lane_ctrl),
        .i_subtract (1'b1),
        .i_a        (r_s1_q_first),
        .i_b        (r_s1_q_second),
        .i_cos      (trig_read.cos_v),
        .i_sin      (trig_read.sin_v),
        .o_result   (lane_q_first)
    );

    rpe_lane u_lane_q_second (
        .i_clk      (i_clk),
        .i_ctrl     (lane_ctrl),
        .i_subtract (1'b0),
        .i_a        (r_s1_q_second),
        .i_b        (r_s1_q_first),
        .i_cos      (trig_read.cos_v),
        .i_sin      (trig_read.sin_v),
        .o_result   (lane_q_second)
    );

    rpe_lane u_lane_k_first (
        .i_clk      (i_clk),
        .i_ctrl     (lane_ctrl),
        .i_subtract (1'b1),
        .i_a        (r_s1_k_first),
        .i_b        (r_s1_k_second),
        .i_cos      (trig_read.cos_v),
        .i_sin      (trig_read.sin_v),
        .o_result   (lane_k_first)
    );

    rpe_lane u_lane_k_second (
        .i_clk      (i_clk),
        .i_ctrl     (lane_ctrl),
        .i_subtract (1'b0),
        .i_a        (r_s1_k_second),
        .i_b        (r_s1_k_first),
        .i_cos      (trig_read.cos_v),
        .i_sin      (trig_read.sin_v),
        .o_result   (lane_k_second)
    );

    // Merge: lane results and cache routing leave together as one transaction.
    assign o_out.valid        = r_s3_valid;
    assign o_out.q_first_out  = lane_q_first;
    assign o_out.q_second_out = lane_q_second;
    assign o_out.k_first_out  = lane_k_first;
    assign o_out.k_second_out = lane_k_second;
    assign o_out.cache_select = r_s3_sel;
    assign o_out.cache_row    = r_s3_row;

    `ASSERT_NEXT(a_rotate_enters, i_clk, i_rst_n, accept_rotate, r_s1_valid,
        "rotate lost at entry")
    `ASSERT_NEXT(a_load_no_result, i_clk, i_rst_n, accept_load, !r_s1_valid,
        "load made a result")
    `ASSERT_NEXT(a_s2_holds, i_clk, i_rst_n, r_s2_valid && !adv3, r_s2_valid,
        "stalled item dropped")
    `ASSERT_ALWAYS(a_full_when_blocked, i_clk, i_rst_n,
        i_in.ready || (r_s1_valid && r_s2_valid && r_s3_valid),
        "input blocked with a bubble")

endmodule

### bench/tb_rotary_position_embedding_pair_core.sv
`timescale 1ns / 1ps

module tb_rotary_position_embedding_pair_core import rpe_pkg::*; ();

    // Run bounds: the limit leaves a wide margin over the slowest legal run, with
    // every gap and stall at its longest.
    localparam int CYCLE_LIMIT     = 400000;
    localparam int HOLD_OFF        = 8;     // pipeline is 3 deep; wait a little longer
    localparam int ITEMS_PER_PHASE = 120;
    localparam int PRINT_CAP       = 40;

    // Handy trig and data corners in Q2.16 and Q14.18.
    localparam t_trig TRIG_ZERO    = 18'sh00000;
    localparam t_trig TRIG_ONE     = 18'sh10000;   // +1.0
    localparam t_trig TRIG_NEG_ONE = 18'sh30000;   // -1.0
    localparam t_trig TRIG_MAX     = 18'sh1FFFF;
    localparam t_trig TRIG_MIN     = 18'sh20000;   // -2.0
    localparam t_trig TRIG_LSB     = 18'sh00001;
    localparam t_data DATA_MAX     = 32'sh7FFF_FFFF;
    localparam t_data DATA_MIN     = 32'sh8000_0000;

    typedef struct packed {
        t_op               op;
        logic [POS_W-1:0]  pos;
        logic [SLOT_W-1:0] slot;
        t_trig             c;
        t_trig             s;
        t_data             qf;
        t_data             qs;
        t_data             kf;
        t_data             ks;
    } t_rope_item;

    typedef struct packed {
        t_data            qf;
        t_data            qs;
        t_data            kf;
        t_data            ks;
        logic             sel;
        logic [POS_W-1:0] row;
    } t_rope_result;

    // One directed row: the transaction, and a hand-written result where the
    // answer is obvious; other rows fall back to the predictor.
    typedef struct packed {
        t_rope_item   item;
        logic         typed;
        t_rope_result res;
    } t_stim_row;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               cfg_we;
    logic [SPLIT_W-1:0] cfg_wdata;

    rpe_in_if  in_bus ();
    rpe_out_if out_bus ();

    rotary_position_embedding_pair_core dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in        (in_bus),
        .o_out       (out_bus),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    always #10 clk = ~clk;

    // Shadow of the block: trig tables, split register, and which entries hold data.
    t_trig              cos_shadow [TBL_DEPTH];
    t_trig              sin_shadow [TBL_DEPTH];
    bit                 loaded_map [TBL_DEPTH];
    t_tbl_addr          loaded_addrs [$];
    t_tbl_addr          last_load;
    logic [SPLIT_W-1:0] split_shadow = SPLIT_RESET;

    // Rotations accepted whose result has not come out yet, oldest first.
    t_rope_result pending_rotations [$];

    int n_loads    = 0;
    int n_rotates  = 0;
    int n_checked  = 0;
    int n_mismatch = 0;
    int n_settings = 1;
    int send_calm  = 0;
    int recv_calm  = 0;
    int cycle_count = 0;

    function automatic t_rope_item mk_item(t_op op, logic [POS_W-1:0] pos,
                                           logic [SLOT_W-1:0] slot, t_trig c, t_trig s,
                                           t_data qf, t_data qs, t_data kf, t_data ks);
        t_rope_item it;
        it = '{op, pos, slot, c, s, qf, qs, kf, ks};
        return it;
    endfunction

    function automatic t_rope_result mk_res(t_data qf, t_data qs, t_data kf, t_data ks,
                                            logic sel, logic [POS_W-1:0] row);
        t_rope_result r;
        r = '{qf, qs, kf, ks, sel, row};
        return r;
    endfunction

    // Mostly a random wait, with occasional stretches of back-to-back traffic.
    function automatic int pick_wait(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 39) == 0) calm = int'($urandom_range(10, 40));
        return int'($urandom_range(0, 8));
    endfunction

    function automatic t_data pick_data();
        case ($urandom_range(0, 9))
            0: return DATA_MAX;
            1: return DATA_MIN;
            2: return t_data'($urandom_range(0, 2097151)) - t_data'(1048576);
            default: return t_data'($urandom);
        endcase
    endfunction

    function automatic t_trig pick_trig();
        case ($urandom_range(0, 9))
            0: return TRIG_MAX;
            1: return TRIG_MIN;
            2: return TRIG_ONE;
            3: return TRIG_NEG_ONE;
            default: return t_trig'($urandom);
        endcase
    endfunction

    // x*c -/+ y*s: floor each product to 18 fraction bits, then saturate the sum.
    function automatic t_data rotate_lane(t_data x, t_data y, t_trig cw, t_trig sw,
                                          bit subtract);
        logic signed [49:0] xw, yw, cwide, swide;
        logic signed [34:0] px, py, acc;
        xw    = x;
        yw    = y;
        cwide = cw;
        swide = sw;
        px    = 35'((xw * cwide) >>> PROD_SHIFT);
        py    = 35'((yw * swide) >>> PROD_SHIFT);
        acc   = subtract ? px - py : px + py;
        // Out of range when the top bits are not all copies of the sign.
        if (acc[34:31] != {4{acc[34]}}) return acc[34] ? DATA_MIN : DATA_MAX;
        return acc[31:0];
    endfunction

    // Apply one accepted transaction to the shadow; return 1 with the predicted
    // result for a rotation, 0 for a table load.
    function automatic bit track_transaction(t_rope_item it, output t_rope_result r);
        t_tbl_addr          a;
        t_trig              cw, sw;
        logic [SPLIT_W-1:0] diff;
        bit                 second;
        a = {it.pos, it.slot};
        r = '0;
        if (it.op == OP_LOAD) begin
            cos_shadow[a] = it.c;
            sin_shadow[a] = it.s;
            if (!loaded_map[a]) begin
                loaded_map[a] = 1'b1;
                loaded_addrs.push_back(a);
            end
            last_load = a;
            n_loads++;
            return 1'b0;
        end
        cw     = cos_shadow[a];
        sw     = sin_shadow[a];
        r.qf   = rotate_lane(it.qf, it.qs, cw, sw, 1'b1);
        r.qs   = rotate_lane(it.qs, it.qf, cw, sw, 1'b0);
        r.kf   = rotate_lane(it.kf, it.ks, cw, sw, 1'b1);
        r.ks   = rotate_lane(it.ks, it.kf, cw, sw, 1'b0);
        second = {1'b0, it.pos} >= split_shadow;
        diff   = {1'b0, it.pos} - split_shadow;
        r.sel  = second;
        r.row  = second ? diff[POS_W-1:0] : it.pos;
        n_rotates++;
        return 1'b1;
    endfunction

    task automatic report_mismatch(string msg);
        if (n_mismatch < PRINT_CAP) $display("MISMATCH @%0t: %s", $realtime, msg);
        n_mismatch++;
    endtask

    task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %h want %h", name, got, want));
    endtask

    // Present one transaction after a random gap and hold it until accepted.
    // Drop valid only when a gap follows, so valid never toggles within a step.
    task automatic drive_item(t_rope_item it);
        int gap;
        gap = pick_wait(send_calm);
        if (gap > 0) begin
            in_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_bus.valid     <= 1'b1;
        in_bus.operation <= it.op;
        in_bus.position  <= it.pos;
        in_bus.pair_slot <= it.slot;
        in_bus.trig_cos  <= it.c;
        in_bus.trig_sin  <= it.s;
        in_bus.q_first   <= it.qf;
        in_bus.q_second  <= it.qs;
        in_bus.k_first   <= it.kf;
        in_bus.k_second  <= it.ks;
        @(posedge clk);
        while (!in_bus.ready) @(posedge clk);
    endtask

    // Hold the sender until every rotation is out, then let stray loads settle.
    task automatic drain_rotations();
        in_bus.valid <= 1'b0;
        while (pending_rotations.size() != 0) @(posedge clk);
        repeat (HOLD_OFF) @(posedge clk);
    endtask

    // Watchdog: end the run if the pipeline hangs.
    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles, %0d rotations pending",
                 cycle_count, pending_rotations.size());
        $display("[FAIL] regression broken");
        $finish;
    end

    // Result side: stall at random, then take one transaction and compare it
    // against the oldest pending rotation.
    initial begin : result_sink
        int           stall;
        t_rope_result got;
        t_rope_result want;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            stall = pick_wait(recv_calm);
            if (stall > 0) begin
                out_bus.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_bus.ready <= 1'b1;
            @(posedge clk);
            while (!out_bus.valid) @(posedge clk);
            got = '{out_bus.q_first_out, out_bus.q_second_out, out_bus.k_first_out,
                    out_bus.k_second_out, out_bus.cache_select, out_bus.cache_row};
            if (pending_rotations.size() == 0) begin
                report_mismatch($sformatf("result with nothing pending: %h", got));
            end else begin
                want = pending_rotations.pop_front();
                n_checked++;
                check_field("q_first_out",  got.qf, want.qf);
                check_field("q_second_out", got.qs, want.qs);
                check_field("k_first_out",  got.kf, want.kf);
                check_field("k_second_out", got.ks, want.ks);
                check_field("cache_select", 32'(got.sel), 32'(want.sel));
                check_field("cache_row",    32'(got.row), 32'(want.row));
            end
        end
    end

    initial begin : main_seq
        t_stim_row          dir_rows [$];
        t_rope_result       predicted;
        logic [SPLIT_W-1:0] split_plan [6];

        // Drive every input to a known value from time zero.
        rst_n            <= 1'b0;
        cfg_we           <= 1'b0;
        cfg_wdata        <= '0;
        in_bus.valid     <= 1'b0;
        in_bus.operation <= OP_LOAD;
        in_bus.position  <= '0;
        in_bus.pair_slot <= '0;
        in_bus.trig_cos  <= '0;
        in_bus.trig_sin  <= '0;
        in_bus.q_first   <= '0;
        in_bus.q_second  <= '0;
        in_bus.k_first   <= '0;
        in_bus.k_second  <= '0;
        out_bus.ready    <= 1'b0;

        // Directed rows, run at the reset split of 800. Every rotation reads an
        // entry loaded earlier in the table.
        // Identity angle passes data through; corners at the first entry.
        dir_rows.push_back('{mk_item(OP_LOAD, 10'd0, 4'd0, TRIG_ONE, TRIG_ZERO,
                                     '0, '0, '0, '0), 1'b0, '0});
        dir_rows.push_back('{mk_item(OP_ROTATE, 10'd0, 4'd0, '0, '0,
                                     DATA_MAX, DATA_MIN, 32'sh1234_5678, 32'shEDCB_A987),
                             1'b1, mk_res(DATA_MAX, DATA_MIN, 32'sh1234_5678,
                                          32'shEDCB_A987, 1'b0, 10'd0)});
        // cos = -2.0 doubles and negates: both query lanes saturate.
        dir_rows.push_back('{mk_item(OP_LOAD, 10'd1023, 4'd15, TRIG_MIN, TRIG_ZERO,
                                     '0, '0, '0, '0), 1'b0, '0});
        dir_rows.push_back('{mk_item(OP_ROTATE, 10'd1023, 4'd15, '0, '0,
                                     DATA_MAX, DATA_MIN, 32'sh0, 32'sh1),
                             1'b1, mk_res(DATA_MIN, DATA_MAX, 32'sh0, 32'shFFFF_FFFE,
                                          1'b1, 10'd223)});
        // Smallest cosine: negative products floor to -1, positive ones to 0.
        dir_rows.push_back('{mk_item(OP_LOAD, 10'd799, 4'd8, TRIG_LSB, TRIG_ZERO,
                                     '0, '0, '0, '0), 1'b0, '0});
        dir_rows.push_back('{mk_item(OP_ROTATE, 10'd799, 4'd8, '0, '0,
                                     32'shFFFF_FFFF, 32'sh1, 32'shFFFF_0000, 32'sh0000_FFFF),
                             1'b1, mk_res(32'shFFFF_FFFF, 32'sh0, 32'shFFFF_FFFF, 32'sh0,
                                          1'b0, 10'd799)});
        // Quarter turn at the first row of the second cache; -MIN saturates.
        dir_rows.push_back('{mk_item(OP_LOAD, 10'd800, 4'd7, TRIG_ZERO, TRIG_ONE,
                                     '0, '0, '0, '0), 1'b0, '0});
        dir_rows.push_back('{mk_item(OP_ROTATE, 10'd800, 4'd7, '0, '0,
                                     32'sh5, DATA_MIN, DATA_MIN, DATA_MAX),
                             1'b1, mk_res(DATA_MAX, 32'sh5, 32'sh8000_0001, DATA_MIN,
                                          1'b1, 10'd0)});
        // Zero angle entry wipes everything.
        dir_rows.push_back('{mk_item(OP_LOAD, 10'd512, 4'd3, TRIG_ZERO, TRIG_ZERO,
                                     '0, '0, '0, '0), 1'b0, '0});
        dir_rows.push_back('{mk_item(OP_ROTATE, 10'd512, 4'd3, '0, '0,
                                     32'shDEAD_BEEF, DATA_MIN, DATA_MAX, 32'sh0BAD_F00D),
                             1'b1, mk_res(32'sh0, 32'sh0, 32'sh0, 32'sh0, 1'b0, 10'd512)});
        // Trig extremes, then overwrite the same entry and rotate again.
        dir_rows.push_back('{mk_item(OP_LOAD, 10'd1, 4'd1, TRIG_MAX, TRIG_MIN,
                                     '0, '0, '0, '0), 1'b0, '0});
        dir_rows.push_back('{mk_item(OP_ROTATE, 10'd1, 4'd1, '0, '0,
                                     DATA_MIN, DATA_MIN, DATA_MAX, DATA_MAX), 1'b0, '0});
        dir_rows.push_back('{mk_item(OP_ROTATE, 10'd1, 4'd1, '0, '0,
                                     32'sh0004_0000, 32'shFFFC_0000, 32'sh1, 32'shFFFF_FFFF),
                             1'b0, '0});
        dir_rows.push_back('{mk_item(OP_LOAD, 10'd1, 4'd1, TRIG_MIN, TRIG_MAX,
                                     '0, '0, '0, '0), 1'b0, '0});
        dir_rows.push_back('{mk_item(OP_ROTATE, 10'd1, 4'd1, '0, '0,
                                     DATA_MAX, DATA_MIN, DATA_MIN, DATA_MAX), 1'b0, '0});
        // A 45 degree turn on unit data, and a nearly -1.0 angle.
        dir_rows.push_back('{mk_item(OP_LOAD, 10'd600, 4'd12, 18'sh0B504, 18'sh0B504,
                                     '0, '0, '0, '0), 1'b0, '0});
        dir_rows.push_back('{mk_item(OP_ROTATE, 10'd600, 4'd12, '0, '0,
                                     32'sh0004_0000, 32'sh0004_0000, 32'shFFFC_0000,
                                     32'sh0004_0000), 1'b0, '0});
        dir_rows.push_back('{mk_item(OP_LOAD, 10'd1000, 4'd0, TRIG_NEG_ONE, 18'sh3FFFF,
                                     '0, '0, '0, '0), 1'b0, '0});
        dir_rows.push_back('{mk_item(OP_ROTATE, 10'd1000, 4'd0, '0, '0,
                                     DATA_MAX, DATA_MAX, DATA_MIN, DATA_MIN), 1'b0, '0});

        // Split settings after the reset value: both ends of the range, the
        // values next to them, one random point, then back to the reset value.
        split_plan = '{11'd0, 11'd1024, 11'd1, 11'd1023,
                       SPLIT_W'($urandom_range(2, 1022)), SPLIT_RESET};

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i]) begin
            drive_item(dir_rows[i].item);
            if (track_transaction(dir_rows[i].item, predicted))
                pending_rotations.push_back(dir_rows[i].typed ? dir_rows[i].res : predicted);
        end

        for (int ph = 0; ph <= 6; ph++) begin
            // Move the split only with the pipeline empty.
            if (ph > 0) begin
                drain_rotations();
                cfg_we       <= 1'b1;
                cfg_wdata    <= split_plan[ph-1];
                @(posedge clk);
                cfg_we       <= 1'b0;
                split_shadow  = split_plan[ph-1];
                n_settings++;
            end
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin : rand_item
                t_rope_item   it;
                t_rope_result r;
                t_tbl_addr    pick;
                // Unused fields carry noise on both kinds of transaction.
                it.c  = pick_trig();
                it.s  = pick_trig();
                it.qf = pick_data();
                it.qs = pick_data();
                it.kf = pick_data();
                it.ks = pick_data();
                if (loaded_addrs.size() == 0 || $urandom_range(0, 99) < 35) begin
                    it.op = OP_LOAD;
                    // Bias positions toward the ends and the current split.
                    case ($urandom_range(0, 7))
                        0: it.pos = '0;
                        1: it.pos = '1;
                        2: it.pos = split_shadow[POS_W-1:0];
                        3: it.pos = POS_W'(split_shadow - 11'd1);
                        default: it.pos = POS_W'($urandom);
                    endcase
                    it.slot = SLOT_W'($urandom);
                end else begin
                    // Read only loaded entries; often the one just written.
                    it.op = OP_ROTATE;
                    pick  = ($urandom_range(0, 3) == 0) ? last_load :
                            loaded_addrs[$urandom_range(0, loaded_addrs.size() - 1)];
                    it.pos  = pick[TBL_AW-1:SLOT_W];
                    it.slot = pick[SLOT_W-1:0];
                end
                drive_item(it);
                if (track_transaction(it, r)) pending_rotations.push_back(r);
            end
        end

        drain_rotations();

        $display("Covered %0d trig loads and %0d rotations over %0d split settings",
                 n_loads, n_rotates, n_settings);
        $display("Checked %0d rotated results field by field, %0d mismatches",
                 n_checked, n_mismatch);
        if (n_mismatch == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
